// File: src/pdf_pkg.sv
// ----------------------------------------------------------------------------
// pdf_pkg
// Shared constants, types and codes of the polyline distance block.
// ----------------------------------------------------------------------------
package pdf_pkg;

   localparam int MaxVertices = 64;
   localparam int AddrW       = $clog2(MaxVertices);
   localparam int CountW      = $clog2(MaxVertices + 1);
   localparam int CoordW      = 16;
   localparam int DistW       = 17;

   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;
   localparam logic [1:0] OP_NONE   = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FEW   = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_RD0,
      S_RD1,
      S_SEG,
      S_MUL,
      S_DIV,
      S_RES,
      S_SQ,
      S_MIN,
      S_SQRT,
      S_OUT
   } state_type;

endpackage

// File: src/polyline_distance_field.sv
// ----------------------------------------------------------------------------
// polyline_distance_field
// Distance from a query point to a stored polyline, in unsigned Q5.12.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  req_     in         req_valid / req_ready  op, x, y, offset_x, offset_y
//  rsp_     out        rsp_valid / rsp_ready  distance, status
//
// Clear, append, the unused op and a query on a short table go straight to
// the output state S_OUT, from which rsp_valid is registered. A query reads
// the vertex memory one vertex at a time: it starts in S_RD0, then takes each
// segment through S_RD1, S_SEG, S_MUL, the 16-step radix-2 divider for the
// projection parameter (whose steps are skipped when the parameter clamps to
// 0 or 1), S_RES, S_SQ and S_MIN, then ends with the bit-serial square root
// and the output state. Reset empties the table at once (the count goes
// to zero); the memory contents are not cleared. One beat is in flight at a
// time; a stalled response holds the block but the result register keeps
// its value, and the next request beat can be taken from the cycle after
// the response beat.
// ----------------------------------------------------------------------------
module polyline_distance_field
   import pdf_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [1:0]              req_op,
   input  logic signed [CoordW-1:0] req_x,
   input  logic signed [CoordW-1:0] req_y,
   input  logic signed [CoordW-1:0] req_offset_x,
   input  logic signed [CoordW-1:0] req_offset_y,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [DistW-1:0]        rsp_distance,
   output logic [1:0]              rsp_status
);

   state_type state_ff, state_in;
   logic [CountW-1:0] count_ff, count_in;
   logic [AddrW-1:0]  k_ff, k_in;      // current vertex address
   logic signed [16:0] qx_ff, qy_ff;
   logic signed [15:0] ax_ff, ay_ff;   // vertex k
   logic signed [15:0] bx_ff, by_ff;   // vertex k+1
   logic signed [17:0] wx_ff, wy_ff;
   logic signed [16:0] ex_ff, ey_ff;
   logic signed [35:0] pwx_ff, pwy_ff, pex_ff, pey_ff;
   logic signed [36:0] we_ff;
   logic [35:0]        ee_ff;
   logic [16:0]        t_ff;           // Q1.16, up to 65536
   logic [36:0]        rem_ff;
   logic [4:0]         cnt_ff;
   logic signed [25:0] rx_ff, ry_ff;   // residual Q.12
   logic [51:0]        sx_ff, sy_ff;
   logic [52:0]        best_ff;
   logic [53:0]        n_ff;           // sqrt remainder
   logic [27:0]        root_ff;
   logic [DistW-1:0]   dist_ff;
   logic [1:0]         status_ff;
   logic               rsp_valid_ff;

   // Vertex memories: one address, used for write on append, read on query.
   logic               mem_we;
   logic [AddrW-1:0]   mem_addr;
   logic signed [15:0] rdx, rdy;

   assign mem_we   = (state_ff == S_IDLE) && req_valid && req_ready &&
                     req_op == OP_APPEND && count_ff < CountW'(MaxVertices);
   assign mem_addr = (state_ff == S_IDLE) ? count_ff[AddrW-1:0] : k_ff;

   pdf_ram #(.Width(16), .Depth(MaxVertices)) u_ram_x (
      .clock, .wr_en(mem_we), .addr(mem_addr), .wr_data(req_x), .rd_data(rdx));
   pdf_ram #(.Width(16), .Depth(MaxVertices)) u_ram_y (
      .clock, .wr_en(mem_we), .addr(mem_addr), .wr_data(req_y), .rd_data(rdy));

   assign req_ready    = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_distance = dist_ff;
   assign rsp_status   = status_ff;

   // Divider step (restoring, one quotient bit per cycle).
   logic [37:0] rem_sh;
   logic [37:0] rem_sub;
   assign rem_sh  = {rem_ff, 1'b0};
   assign rem_sub = rem_sh - {2'b0, ee_ff};

   // Residual: w*65536 - e*t, rounded half up to Q.12.
   logic signed [43:0] etx, ety, resx, resy;
   assign etx  = 44'(ex_ff) * $signed({1'b0, t_ff});
   assign ety  = 44'(ey_ff) * $signed({1'b0, t_ff});
   assign resx = ({{26{wx_ff[17]}}, wx_ff} <<< 16) - etx + 44'sd32768;
   assign resy = ({{26{wy_ff[17]}}, wy_ff} <<< 16) - ety + 44'sd32768;

   logic [52:0] d2;
   assign d2 = 53'(sx_ff) + 53'(sy_ff);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      k_in     = k_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               case (req_op)
                  OP_CLEAR: begin
                     count_in = '0;
                     state_in = S_OUT;
                  end
                  OP_APPEND: begin
                     if (count_ff < CountW'(MaxVertices)) count_in = count_ff + 1'b1;
                     state_in = S_OUT;
                  end
                  OP_QUERY: begin
                     k_in = '0;
                     state_in = (count_ff < CountW'(2)) ? S_OUT : S_RD0;
                  end
                  default: state_in = S_OUT;
               endcase
            end
         end
         S_RD0: begin
            k_in = k_ff + 1'b1;
            state_in = S_RD1;
         end
         S_RD1: state_in = S_SEG;
         S_SEG: state_in = S_MUL;
         S_MUL: state_in = S_DIV;
         // Count 17 ends a full division, count 18 marks a clamped parameter.
         S_DIV: if (cnt_ff == 5'd17 || cnt_ff == 5'd18) state_in = S_RES;
         S_RES: state_in = S_SQ;
         S_SQ:  state_in = S_MIN;
         S_MIN: begin
            if ({1'b0, k_ff} + 1'b1 >= {1'b0, count_ff}) begin
               state_in = S_SQRT;
            end else begin
               k_in = k_ff + 1'b1;
               state_in = S_RD1;
            end
         end
         S_SQRT: if (cnt_ff == 5'd26) state_in = S_OUT;
         S_OUT:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         k_ff     <= k_in;
         if (state_ff == S_OUT) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               qx_ff     <= 17'(req_x) + 17'(req_offset_x);
               qy_ff     <= 17'(req_y) + 17'(req_offset_y);
               dist_ff   <= '0;
               best_ff   <= '1;
               status_ff <= (req_op == OP_APPEND && count_ff >= CountW'(MaxVertices)) ?
                            ST_FULL :
                            (req_op == OP_QUERY && count_ff < CountW'(2)) ? ST_FEW : ST_OK;
            end
         end
         S_RD1: begin
            // Data of the previous address is vertex k; advance for k+1.
            if (k_ff == AddrW'(1)) begin
               ax_ff <= rdx;
               ay_ff <= rdy;
            end else begin
               ax_ff <= bx_ff;
               ay_ff <= by_ff;
            end
            cnt_ff <= 5'd31;
         end
         S_SEG: begin
            bx_ff <= rdx;
            by_ff <= rdy;
            ex_ff <= 17'(rdx) - 17'(ax_ff);
            ey_ff <= 17'(rdy) - 17'(ay_ff);
            wx_ff <= 18'(qx_ff) - 18'(ax_ff);
            wy_ff <= 18'(qy_ff) - 18'(ay_ff);
         end
         S_MUL: begin
            pwx_ff <= 36'(wx_ff) * 36'(ex_ff);
            pwy_ff <= 36'(wy_ff) * 36'(ey_ff);
            pex_ff <= 36'(ex_ff) * 36'(ex_ff);
            pey_ff <= 36'(ey_ff) * 36'(ey_ff);
            cnt_ff <= 5'd0;
         end
         S_DIV: begin
            if (cnt_ff == 5'd0) begin
               we_ff  <= 37'(pwx_ff) + 37'(pwy_ff);
               ee_ff  <= 36'(pex_ff + pey_ff);
               rem_ff <= 37'(pwx_ff) + 37'(pwy_ff);
               t_ff   <= '0;
            end else if (cnt_ff == 5'd1) begin
               // Clamp cases skip the division; otherwise rem starts as we.
               if (ee_ff == '0 || we_ff <= 0) begin
                  t_ff <= '0;
                  cnt_ff <= 5'd18;
               end else if (we_ff >= $signed({1'b0, ee_ff})) begin
                  t_ff <= 17'd65536;
                  cnt_ff <= 5'd18;
               end
            end else if (cnt_ff != 5'd18) begin
               if (!rem_sub[37]) begin
                  rem_ff <= rem_sub[36:0];
                  t_ff   <= {t_ff[15:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh[36:0];
                  t_ff   <= {t_ff[15:0], 1'b0};
               end
            end
            if (!(cnt_ff == 5'd1 && (ee_ff == '0 || we_ff <= 0 ||
                  we_ff >= $signed({1'b0, ee_ff}))))
               cnt_ff <= cnt_ff + 1'b1;
         end
         S_RES: begin
            rx_ff <= 26'(resx >>> 16);
            ry_ff <= 26'(resy >>> 16);
         end
         S_SQ: begin
            sx_ff <= 52'(rx_ff * rx_ff);
            sy_ff <= 52'(ry_ff * ry_ff);
         end
         S_MIN: begin
            if (d2 < best_ff) begin
               best_ff <= d2;
               n_ff    <= 54'(d2);
            end else begin
               n_ff    <= 54'(best_ff);
            end
            root_ff <= '0;
            cnt_ff  <= 5'd0;
         end
         S_SQRT: begin
            // Bit-serial root: two radicand bits per step, 27 steps.
            if ({n_ff[53:0] >> (2 * (26 - cnt_ff))} >= 54'({root_ff, 2'b01})) begin
               n_ff    <= n_ff - (54'({root_ff, 2'b01}) << (2 * (26 - cnt_ff)));
               root_ff <= {root_ff[26:0], 1'b1};
            end else begin
               root_ff <= {root_ff[26:0], 1'b0};
            end
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == 5'd26) begin
               if ({root_ff[26:0], 1'b1} > 28'd131071 && 
                   ({n_ff >> 0} >= 54'({root_ff, 2'b01})))
                  dist_ff <= 17'd131071;
               else if (({n_ff >> 0} >= 54'({root_ff, 2'b01})))
                  dist_ff <= ({root_ff[26:0], 1'b1} > 28'd131071) ?
                             17'd131071 : 17'({root_ff[26:0], 1'b1});
               else
                  dist_ff <= ({root_ff[26:0], 1'b0} > 28'd131071) ?
                             17'd131071 : 17'({root_ff[26:0], 1'b0});
            end
         end
         default: ;
      endcase
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == S_IDLE) else $error("ready outside idle");
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountW'(MaxVertices)) else $error("count overflow");
   a_status_dist: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_distance == '0)
      else $error("error with distance");

endmodule

// File: src/pdf_ram.sv
// ----------------------------------------------------------------------------
// pdf_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module pdf_ram #(
   parameter int Width = 16,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data <= mem_ff[addr];
   end

endmodule

// File: dv/polyline_distance_field_checker.sv
// ----------------------------------------------------------------------------
// polyline_distance_field_checker
// Watches both channels of the polyline distance block, keeps its own copy
// of the vertex table, predicts each response and compares it field by field.
// ----------------------------------------------------------------------------
module polyline_distance_field_checker
   import pdf_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  logic [1:0]               req_op,
   input  logic signed [CoordW-1:0] req_x,
   input  logic signed [CoordW-1:0] req_y,
   input  logic signed [CoordW-1:0] req_offset_x,
   input  logic signed [CoordW-1:0] req_offset_y,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  logic [DistW-1:0]         rsp_distance,
   input  logic [1:0]               rsp_status,
   output int                       fail_count,
   output int                       pending
);

   typedef struct packed {
      logic [DistW-1:0] distance;
      logic [1:0]       status;
   } answer_type;

   answer_type       answer_q[$];
   longint           vx[MaxVertices];
   longint           vy[MaxVertices];
   int               nverts;

   assign pending = answer_q.size();

   // Round a Q.28 value to Q.12, half toward plus infinity.
   function automatic longint to_q12(longint v);
      return (v + 32768) >>> 16;
   endfunction

   function automatic longint int_sqrt(longint unsigned n);
      longint unsigned root, bit_w;
      root  = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > n) bit_w >>= 2;
      while (bit_w != 0) begin
         if (n >= root + bit_w) begin
            n    = n - (root + bit_w);
            root = (root >> 1) + bit_w;
         end else begin
            root >>= 1;
         end
         bit_w >>= 2;
      end
      return root;
   endfunction

   function automatic answer_type predict_distance(logic [1:0] op, longint px, longint py,
                                                   longint ox, longint oy);
      answer_type     a;
      longint         qx, qy, ex, ey, wx, wy, we, ee, t, bx, by;
      longint unsigned best, d2, root;
      a = '0;
      if (op == OP_CLEAR) begin
         nverts = 0;
      end else if (op == OP_APPEND) begin
         if (nverts >= MaxVertices) begin
            a.status = ST_FULL;
         end else begin
            vx[nverts] = px;
            vy[nverts] = py;
            nverts++;
         end
      end else if (op == OP_QUERY) begin
         if (nverts < 2) begin
            a.status = ST_FEW;
         end else begin
            qx   = px + ox;
            qy   = py + oy;
            best = '1;
            for (int k = 0; k + 1 < nverts; k++) begin
               ex = vx[k+1] - vx[k];
               ey = vy[k+1] - vy[k];
               wx = qx - vx[k];
               wy = qy - vy[k];
               we = wx * ex + wy * ey;
               ee = ex * ex + ey * ey;
               if (ee == 0 || we <= 0) t = 0;
               else if (we >= ee)     t = 65536;
               else                   t = (we * 65536) / ee;
               bx = to_q12(wx * 65536 - ex * t);
               by = to_q12(wy * 65536 - ey * t);
               d2 = bx * bx + by * by;
               if (d2 < best) best = d2;
            end
            root       = int_sqrt(best);
            a.distance = (root > 131071) ? 17'h1ffff : root[DistW-1:0];
         end
      end
      return a;
   endfunction

   always @(posedge clock) begin
      answer_type exp_a;
      if (reset) begin
         nverts     = 0;
         fail_count <= 0;
         answer_q.delete();
      end else begin
         if (req_valid && req_ready)
            answer_q = {answer_q, predict_distance(req_op, req_x, req_y,
                                                   req_offset_x, req_offset_y)};
         if (rsp_valid && rsp_ready) begin
            if (answer_q.size() == 0) begin
               $display("%0t: unexpected beat distance=%0d status=%0d", $time,
                        rsp_distance, rsp_status);
               fail_count <= fail_count + 1;
            end else begin
               exp_a = answer_q.pop_front();
               if (exp_a.distance !== rsp_distance || exp_a.status !== rsp_status) begin
                  $display("%0t: expected distance=%0d status=%0d, got distance=%0d status=%0d",
                           $time, exp_a.distance, exp_a.status, rsp_distance, rsp_status);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

// File: dv/polyline_distance_field_tb.sv
// ----------------------------------------------------------------------------
// polyline_distance_field_tb
// Drives table clears, vertex appends and point queries into the block with
// random idling on both channels; a checker beside the block predicts and
// compares every response, and this top gives the verdict.
// ----------------------------------------------------------------------------
module polyline_distance_field_tb;
   import pdf_pkg::*;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic [1:0]               req_op;
   logic signed [CoordW-1:0] req_x, req_y, req_offset_x, req_offset_y;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic [DistW-1:0]         rsp_distance;
   logic [1:0]               rsp_status;
   int                       fail_count;
   int                       pending;

   // Idle rates in percent, and a flag that freezes the receiver for a while.
   int                       send_idle_pct;
   int                       recv_idle_pct;
   bit                       recv_hold;

   polyline_distance_field dut (.*);

   polyline_distance_field_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Receiver: random stalls, changed on the falling edge. While recv_hold is
   // set, ready stays low so that the block fills and stops taking beats.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Present one beat and hold it until accepted. Idle gaps come before valid
   // rises, so valid never drops while a beat is waiting.
   task automatic send_beat(logic [1:0] op, logic [15:0] x, logic [15:0] y,
                            logic [15:0] ox, logic [15:0] oy);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_op       <= op;
      req_x        <= x;
      req_y        <= y;
      req_offset_x <= ox;
      req_offset_y <= oy;
      do @(posedge clock); while (!(req_valid && req_ready));
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // Mostly small coordinates keep distances meaningful; sometimes full range.
   function automatic logic [15:0] pick_coord();
      case ($urandom_range(3))
         0:       return 16'($urandom);
         1:       return $urandom_range(1) ? 16'h7fff : 16'h8000;
         default: return 16'($signed($urandom_range(8191)) - 4096);
      endcase
   endfunction

   // Clear, append a short random polyline, then query it several times.
   task automatic run_polyline(int nv, int nq);
      send_beat(OP_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      for (int i = 0; i < nv; i++)
         send_beat(OP_APPEND, pick_coord(), pick_coord(), 16'($urandom), 16'($urandom));
      for (int i = 0; i < nq; i++)
         send_beat(OP_QUERY, pick_coord(), pick_coord(), pick_coord(), pick_coord());
   endtask

   task automatic random_phase(int beats);
      int sent;
      sent = 0;
      while (sent < beats) begin
         if ($urandom_range(9) == 0) begin
            // Noise: any op, including the unused code and queries on short tables.
            send_beat(2'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom));
            sent++;
         end else begin
            automatic int nv = $urandom_range(2, 6);
            automatic int nq = $urandom_range(1, 4);
            run_polyline(nv, nq);
            sent += nv + nq + 1;
         end
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_op        = OP_CLEAR;
      req_x         = '0;
      req_y         = '0;
      req_offset_x  = '0;
      req_offset_y  = '0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      recv_hold     = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: queries on empty and one-vertex tables, the unused op,
      // a zero-length segment, extreme coordinates and offsets.
      send_beat(OP_QUERY, 16'h0100, 16'h0100, '0, '0);
      send_beat(OP_APPEND, 16'h1000, 16'h1000, '0, '0);
      send_beat(OP_QUERY, '0, '0, '0, '0);
      send_beat(OP_NONE, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
      send_beat(OP_APPEND, 16'h1000, 16'h1000, '0, '0);
      send_beat(OP_QUERY, '0, '0, '0, '0);
      send_beat(OP_APPEND, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
      send_beat(OP_APPEND, 16'h8000, 16'h7fff, '0, '0);
      send_beat(OP_QUERY, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
      send_beat(OP_QUERY, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_beat(OP_QUERY, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
      send_beat(OP_QUERY, 16'h2000, 16'h2000, 16'hf000, 16'h0800);
      send_beat(OP_CLEAR, '0, '0, '0, '0);
      send_beat(OP_QUERY, '0, '0, '0, '0);

      // Fill the table to the top, append past it, then query the full table.
      for (int i = 0; i < MaxVertices + 1; i++)
         send_beat(OP_APPEND, 16'($signed(i * 300) - 9000), pick_coord(), '0, '0);
      send_beat(OP_QUERY, pick_coord(), pick_coord(), '0, '0);

      // Receiver holds off for a long stretch while beats keep coming.
      fork
         begin
            recv_hold = 1'b1;
            repeat (400) @(posedge clock);
            recv_hold = 1'b0;
         end
         run_polyline(3, 4);
      join

      // Sender pauses until every response has drained.
      while (pending != 0) @(negedge clock);

      send_idle_pct = 13;
      recv_idle_pct = 56;
      random_phase(100);
      send_idle_pct = 56;
      recv_idle_pct = 13;
      random_phase(100);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_phase(100);

      while (pending != 0) @(negedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #30000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// File: files.f
src/pdf_pkg.sv
src/pdf_ram.sv
src/polyline_distance_field.sv
dv/polyline_distance_field_checker.sv
dv/polyline_distance_field_tb.sv
